### rtl/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the spell-check word tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

   // Payload widths fixed by the item format
   localparam int CHAR_W = 8;
   localparam int LINE_W = 32;

   // Word length limit: default and the largest value supported
   localparam int LONG_LIMIT_DEF = 20;
   localparam int LIMIT_MAX      = 64;

   // Width of a word character count in a descriptor (holds LIMIT_MAX)
   localparam int CNT_W = $clog2(LIMIT_MAX + 1);

   // Two word buffer banks: one being filled, one being drained
   localparam int BANK_CNT = 2;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NL     = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_APOS   = 8'd39;
   localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_BIT    = 8'h20;

   // Finished word handed from front to back
   typedef struct packed {
      logic              bank;
      logic [CNT_W-1:0]  count;
      logic              is_long;
      logic [LINE_W-1:0] line;
   } desc_type;

   // Occupancy seen by the front: queued words and the word being drained
   typedef struct packed {
      logic [1:0] level;
      logic       active;
   } wbuf_status_type;

endpackage

### rtl/sct_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_req_if
// Text byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface sct_req_if import sct_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

### rtl/sct_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_rsp_if
// Word character channel: valid/ready handshake, one character per item.
// ----------------------------------------------------------------------------
interface sct_rsp_if import sct_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] word_char;
   logic              word_kind;
   logic [LINE_W-1:0] line_number;
   logic              last_char;

   modport source (output valid, output word_char, output word_kind,
                   output line_number, output last_char, input ready);
   modport sink   (input valid, input word_char, input word_kind,
                   input line_number, input last_char, output ready);
endinterface

### rtl/sct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds its value when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_front
// Accepts text bytes, classifies them, fills the word buffer and hands
// finished words to the descriptor queue. Keeps the line counter.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; #(
   parameter int LONG_LIMIT = LONG_LIMIT_DEF,
   parameter int ADDR_W     = $clog2(2 * LONG_LIMIT)
) (
   input  logic              clock,
   input  logic              reset,
   sct_req_if.sink           req_ch,
   input  wbuf_status_type   status,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [CHAR_W-1:0] wr_data,
   output logic              push,
   output desc_type          push_desc
);

   localparam int LEN_W = $clog2(LONG_LIMIT + 2);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              digit_ff, digit_in;
   logic              bank_ff, bank_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic [CHAR_W-1:0] folded;
   logic              is_digit;
   logic              is_word;
   logic              accept;
   logic              is_long;
   logic [2:0]        occupied;

   // Stall while both banks hold words that are not yet drained
   assign occupied     = {1'b0, status.level} + {2'b00, status.active};
   assign req_ch.ready = (occupied < 3'(BANK_CNT));
   assign accept       = req_ch.valid && req_ch.ready;

   // Case folding and character class
   always_comb begin
      folded   = req_ch.text_byte;
      is_digit = 1'b0;
      is_word  = 1'b0;
      case (req_ch.text_byte) inside
         [CHAR_UP_A:CHAR_UP_Z]: folded = req_ch.text_byte | CASE_BIT;
         default: ;
      endcase
      case (folded) inside
         [CHAR_ZERO:CHAR_NINE]: begin
            is_digit = 1'b1;
            is_word  = 1'b1;
         end
         [CHAR_LOW_A:CHAR_LOW_Z], CHAR_HYPHEN, CHAR_APOS: begin
            is_word = 1'b1;
         end
         default: ;
      endcase
   end

   // Buffer write into the current bank
   assign is_long = (len_ff > LEN_W'(LONG_LIMIT));
   assign wr_en   = accept && is_word && (len_ff < LEN_W'(LONG_LIMIT));
   assign wr_addr = ADDR_W'(len_ff) + (bank_ff ? ADDR_W'(LONG_LIMIT) : '0);
   assign wr_data = folded;

   // Word end: push a descriptor unless the word held a digit
   assign push = accept && !is_word && (len_ff != '0) && !digit_ff;
   always_comb begin
      push_desc.bank    = bank_ff;
      push_desc.count   = is_long ? CNT_W'(LONG_LIMIT) : CNT_W'(len_ff);
      push_desc.is_long = is_long;
      push_desc.line    = line_ff;
   end

   // Word and line state update
   always_comb begin
      len_in   = len_ff;
      digit_in = digit_ff;
      bank_in  = bank_ff;
      line_in  = line_ff;
      if (accept) begin
         if (is_word) begin
            digit_in = digit_ff | is_digit;
            if (len_ff < LEN_W'(LONG_LIMIT + 1)) begin
               len_in = len_ff + LEN_W'(1);
            end
         end else if (len_ff != '0) begin
            len_in   = '0;
            digit_in = 1'b0;
            if (push) begin
               bank_in = !bank_ff;
            end
         end
         if (folded == CHAR_NL && line_ff != '1) begin
            line_in = line_ff + LINE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         digit_ff <= 1'b0;
         bank_ff  <= 1'b0;
         line_ff  <= LINE_W'(1);
      end else begin
         len_ff   <= len_in;
         digit_ff <= digit_in;
         bank_ff  <= bank_in;
         line_ff  <= line_in;
      end
   end

endmodule

### rtl/sct_desc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_desc_queue
// Two-entry queue of finished word descriptors between front and back.
// ----------------------------------------------------------------------------
module sct_desc_queue import sct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  desc_type   push_desc,
   input  logic       pop,
   output logic       head_valid,
   output desc_type   head_desc,
   output logic [1:0] level
);

   desc_type   entry_ff [BANK_CNT];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;
   logic       do_push;
   logic       do_pop;

   assign do_push    = push && (level_ff != 2'(BANK_CNT));
   assign do_pop     = pop && (level_ff != '0);
   assign head_valid = (level_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

   // Pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      level_in  = level_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### rtl/sct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_back
// Drains one word at a time from the buffer, one character per cycle unless
// stalled. The RAM read register doubles as the character output register.
// ----------------------------------------------------------------------------
module sct_back import sct_pkg::*; #(
   parameter int LONG_LIMIT = LONG_LIMIT_DEF,
   parameter int ADDR_W     = $clog2(2 * LONG_LIMIT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  desc_type          head_desc,
   output logic              pop,
   output logic              active,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [CHAR_W-1:0] rd_data,
   sct_rsp_if.source         rsp_ch
);

   logic              act_ff, act_in;
   logic              bank_ff, bank_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              long_ff, long_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [LINE_W-1:0] out_line_ff, out_line_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic              issue;
   logic              last_idx;

   // Output stage moves when empty or taken
   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign issue    = act_ff && advance;
   assign last_idx = (idx_ff == cnt_ff - CNT_W'(1));
   assign pop      = head_valid && (!act_ff || (issue && last_idx));
   assign active   = act_ff;

   assign rd_en   = issue;
   assign rd_addr = ADDR_W'(idx_ff) + (bank_ff ? ADDR_W'(LONG_LIMIT) : '0);

   // Drain sequencer
   always_comb begin
      act_in       = act_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      long_in      = long_ff;
      line_in      = line_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_line_in  = out_line_ff;
      out_last_in  = out_last_ff;
      if (issue) begin
         idx_in       = idx_ff + CNT_W'(1);
         out_valid_in = 1'b1;
         out_kind_in  = long_ff;
         out_line_in  = line_ff;
         out_last_in  = last_idx;
         act_in       = !last_idx;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
      // Next word from the queue
      if (pop) begin
         act_in  = 1'b1;
         bank_in = head_desc.bank;
         idx_in  = '0;
         cnt_in  = head_desc.count;
         long_in = head_desc.is_long;
         line_in = head_desc.line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      long_ff     <= long_in;
      line_ff     <= line_in;
      out_kind_ff <= out_kind_in;
      out_line_ff <= out_line_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.word_char   = rd_data;
   assign rsp_ch.word_kind   = out_kind_ff;
   assign rsp_ch.line_number = out_line_ff;
   assign rsp_ch.last_char   = out_last_ff;

endmodule

### rtl/spell_check_word_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spell_check_word_tokenizer_top
// Word tokenizer: front fills a two-bank word buffer, back drains words.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while a bank is free; a word of n
// characters drains at one character per cycle from the buffer RAM read
// port while the output is not stalled. A word's first character passes the
// queue, sequencer and RAM read register once its ending separator is taken.
// Input stalls only while both banks hold undrained words.
// Reset (synchronous): line counter to 1, word, queue and output emptied.
// ----------------------------------------------------------------------------
module spell_check_word_tokenizer_top import sct_pkg::*; #(
   parameter int LONG_LIMIT = LONG_LIMIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sct_req_if.sink   req_ch,
   sct_rsp_if.source rsp_ch
);

   localparam int DEPTH  = BANK_CNT * LONG_LIMIT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;
   logic              push;
   desc_type          push_desc;
   logic              pop;
   logic              head_valid;
   desc_type          head_desc;
   logic [1:0]        level;
   logic              active;
   wbuf_status_type   status;

   // Buffer occupancy seen by the front
   assign status.level  = level;
   assign status.active = active;

   sct_front #(
      .LONG_LIMIT (LONG_LIMIT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .status    (status),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_desc (push_desc)
   );

   sct_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sct_desc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .level      (level)
   );

   sct_back #(
      .LONG_LIMIT (LONG_LIMIT),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .active     (active),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_ch     (rsp_ch)
   );

endmodule

### rtl/sct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module sct_checker import sct_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_word_char,
   input logic              rsp_word_kind,
   input logic [LINE_W-1:0] rsp_line_number,
   input logic              rsp_last_char
);

   // A stalled character item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_char)
         && $stable(rsp_last_char))
      else $error("rsp item changed while stalled");

   // Nothing is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Line numbers start at one and never wrap to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != '0)
      else $error("line number zero");

   // Characters of one word follow back to back with one kind and line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_char |=> rsp_valid
         && $stable(rsp_word_kind) && $stable(rsp_line_number))
      else $error("word run broken");

endmodule

bind spell_check_word_tokenizer_top sct_checker u_sct_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_word_char   (rsp_ch.word_char),
   .rsp_word_kind   (rsp_ch.word_kind),
   .rsp_line_number (rsp_ch.line_number),
   .rsp_last_char   (rsp_ch.last_char)
);

### sim/word_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_checker
// Watches the text byte and word character channels of the tokenizer. Keeps
// its own copy of the word buffer, length, digit flag and line counter, works
// out the characters each accepted byte releases, and compares every accepted
// character with the oldest one still due.
// ----------------------------------------------------------------------------
module word_tokenizer_checker import sct_pkg::*; #(
   parameter int LONG_LIMIT = LONG_LIMIT_DEF
) (
   input  logic clock,
   input  logic reset,
   sct_req_if   req_mon,
   sct_rsp_if   rsp_mon,
   output int   fail_count,
   output int   chars_due
);

   typedef struct packed {
      logic [CHAR_W-1:0] word_char;
      logic              word_kind;
      logic [LINE_W-1:0] line_number;
      logic              last_char;
   } word_char_type;

   // Characters released by the tokenizer but not yet seen on the output
   word_char_type due_chars [$];

   // Tokenizer state
   logic [CHAR_W-1:0] word_buf [LONG_LIMIT];
   int                word_len;
   logic              seen_digit;
   logic [LINE_W-1:0] line_no;

   // One text byte into the word state; queues any finished word
   task automatic tokenize_byte(input logic [CHAR_W-1:0] text_byte);
      logic [CHAR_W-1:0] c;
      logic              is_digit;
      logic              is_word;
      logic              is_long;
      int                n;
      word_char_type     w;
      c = text_byte;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c | CASE_BIT;
      is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      is_word  = is_digit || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ||
                 c == CHAR_HYPHEN || c == CHAR_APOS;
      if (is_word) begin
         if (is_digit) seen_digit = 1'b1;
         if (word_len < LONG_LIMIT) word_buf[word_len] = c;
         if (word_len < LONG_LIMIT + 1) word_len++;
      end else if (word_len != 0) begin
         // words holding a digit are dropped silently
         if (!seen_digit) begin
            is_long = (word_len > LONG_LIMIT);
            n = is_long ? LONG_LIMIT : word_len;
            for (int k = 0; k < n; k++) begin
               w.word_char   = word_buf[k];
               w.word_kind   = is_long;
               w.line_number = line_no;
               w.last_char   = (k == n - 1);
               due_chars.push_back(w);
            end
         end
         word_len   = 0;
         seen_digit = 1'b0;
      end
      // line moves on after the word that the newline ended
      if (c == CHAR_NL && line_no != '1) line_no++;
   endtask

   // Results are compared before the byte of the same edge is taken in:
   // a character can never come from a byte accepted on the same edge
   always @(posedge clock) begin
      word_char_type got;
      word_char_type want;
      if (reset) begin
         due_chars.delete();
         word_len   = 0;
         seen_digit = 1'b0;
         line_no    = 1;
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.word_char, rsp_mon.word_kind, rsp_mon.line_number,
                    rsp_mon.last_char};
            if (due_chars.size() == 0) begin
               $display("%0t: unexpected char %h kind %b line %0d last %b",
                        $time, got.word_char, got.word_kind, got.line_number,
                        got.last_char);
               fail_count++;
            end else begin
               want = due_chars.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected char %h kind %b line %0d last %b,%s",
                           $time, want.word_char, want.word_kind,
                           want.line_number, want.last_char, "");
                  $display("%0t:           actual   char %h kind %b line %0d last %b",
                           $time, got.word_char, got.word_kind, got.line_number,
                           got.last_char);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) tokenize_byte(req_mon.text_byte);
      end
      chars_due = due_chars.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives text bytes into the word tokenizer and takes its word characters,
// both sides with random gaps and gap-free stretches. A short directed run
// covers separator boundaries, case folding and digit words; random words
// follow, including words at and beyond the length limit. The checker beside
// the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import sct_pkg::*;

   localparam int RANDOM_BYTES = 220;

   logic clock;
   logic reset;
   int   fail_count;
   int   chars_due;
   int   bytes_sent;
   bit   req_calm;
   bit   rsp_calm;

   sct_req_if req_ch ();
   sct_rsp_if rsp_ch ();

   spell_check_word_tokenizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   word_tokenizer_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .chars_due  (chars_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Wait before an item: none during a calm stretch, else drawn at random
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   // One text byte; returns on the falling edge after it is taken
   task automatic send_byte(input logic [CHAR_W-1:0] b);
      int gap;
      gap = draw_gap(req_calm);
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      if (gap != 0) begin
         req_ch.valid     = 1'b0;
         req_ch.text_byte = CHAR_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.text_byte = b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Word of word characters, mixed case, an optional digit at digit_pos
   task automatic send_word(input int len, input int digit_pos);
      logic [CHAR_W-1:0] c;
      int                r;
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 19);
         if (k == digit_pos) c = CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
         else if (r == 0) c = CHAR_HYPHEN;
         else if (r == 1) c = CHAR_APOS;
         else if (r < 11) c = CHAR_W'(CHAR_LOW_A + $urandom_range(0, 25));
         else c = CHAR_W'(CHAR_UP_A + $urandom_range(0, 25));
         send_byte(c);
      end
   endtask

   // Separator: space, newline, tab, a high byte or any byte at all
   task automatic send_separator();
      case ($urandom_range(0, 4))
         0: send_byte(8'd32);
         1: send_byte(CHAR_NL);
         2: send_byte(8'd9);
         3: send_byte(CHAR_W'($urandom_range(128, 255)));
         default: send_byte(CHAR_W'($urandom_range(0, 255)));
      endcase
   endtask

   // Result side: ready after a drawn wait, held until a character is taken
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      rsp_calm     = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         if (gap != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic [CHAR_W-1:0] opening [21];
      int                len;
      int                r;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = '0;
      req_calm         = 1'b0;
      bytes_sent       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // leading separators, an empty line, case folding at the letter
      // extremes with hyphen and apostrophe, a digit word, then the bytes
      // just outside each word-character range
      opening = '{8'd32, 8'd255, CHAR_NL,
                  CHAR_UP_A, CHAR_UP_Z, CHAR_HYPHEN, CHAR_APOS,
                  CHAR_LOW_A, CHAR_LOW_Z, CHAR_NL,
                  8'd120, CHAR_ZERO, CHAR_NINE, 8'd128,
                  8'd47, 8'd58, 8'd64, 8'd91, 8'd96, 8'd123, 8'd0};
      foreach (opening[i]) send_byte(opening[i]);

      // a word exactly at the limit, then one just over it
      send_word(LONG_LIMIT_DEF, -1);
      send_separator();
      send_word(LONG_LIMIT_DEF + 1, -1);
      send_byte(CHAR_NL);

      // random words, mostly short, some around the limit, some with digits
      while (bytes_sent < RANDOM_BYTES) begin
         r = $urandom_range(0, 9);
         if (r < 6) len = $urandom_range(1, 8);
         else if (r < 9) len = $urandom_range(LONG_LIMIT_DEF - 2, LONG_LIMIT_DEF + 4);
         else len = $urandom_range(1, 30);
         send_word(len, ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1);
         repeat ($urandom_range(1, 2)) send_separator();
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3))
            send_byte(CHAR_W'($urandom_range(0, 255)));
      end

      // a word left open when the text stops: never emitted
      send_word(3, -1);
      req_ch.valid = 1'b0;

      while (chars_due != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
